/* rtl/core/bfa_pkg.sv */
// ============================================================================
// bfa_pkg : shared types and constants of the bitmap frame allocator
// Request and status codes, register indexes, sequencer states and the
// configuration bundle passed from the top level to the sequencer.
// ============================================================================
`default_nettype none

package bfa_pkg;

    localparam int FRAME_W   = 17;
    localparam int FIRST_W   = 16;
    localparam int PHYS_W    = 28;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC      = 2'd0,
        OP_FREE       = 2'd1,
        OP_RANGE_FREE = 2'd2,
        OP_RANGE_USED = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOMEM    = 2'd1,
        ST_RANGE    = 2'd2,
        ST_DBL_FREE = 2'd3
    } t_status;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_FRAMES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_LOW = 1'd1;

    localparam logic [FRAME_W-1:0] TOTAL_RESET    = 17'd65536;
    localparam logic [FRAME_W-1:0] RESERVED_RESET = 17'd256;

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_RD,
        S_EVAL,
        S_CNT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [FRAME_W-1:0] total;         // effective managed frame count
        logic [FRAME_W-1:0] reserved;      // range_free floor
        logic               reload;        // total_frames written this cycle
        logic [FRAME_W-1:0] reload_total;  // effective value being written
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/core/bfa_map_ram.sv */
// ============================================================================
// bfa_map_ram : frame bitmap store
// One write port and one read port with registered read data.
// ============================================================================
`default_nettype none

module bfa_map_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 64,
    parameter int AW    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/bfa_word_unit.sv */
// ============================================================================
// bfa_word_unit : shared bitmap word unit
// Masks one bitmap word to a frame window, picks the lowest free frame or
// sets/clears the window, and counts the bits that change.
// ============================================================================
`default_nettype none

module bfa_word_unit #(
    parameter int WORD_W = 64,
    parameter int WBL    = 6
) (
    input  wire logic [WORD_W-1:0] i_word,
    input  wire logic [WBL-1:0]    i_lo,
    input  wire logic [WBL:0]      i_hi,
    input  wire bfa_pkg::t_op      i_op,
    output logic      [WORD_W-1:0] o_word,
    output logic                   o_found,
    output logic      [WBL-1:0]    o_idx,
    output logic      [WBL:0]      o_delta
);

    logic [WORD_W-1:0] w_mask;
    logic [WORD_W-1:0] w_free;
    logic [WORD_W-1:0] w_pick;
    logic [WORD_W-1:0] w_chg;

    // window is bits [lo, hi); a shift by the full width yields zero, so hi = WORD_W keeps every bit from lo up
    assign w_mask = ({WORD_W{1'b1}} << i_lo) & ~({WORD_W{1'b1}} << i_hi);
    assign w_free = ~i_word & w_mask;
    // isolate the lowest free bit
    assign w_pick = w_free & (~w_free + WORD_W'(1));
    assign o_found = |w_pick;

    always_comb begin
        case (i_op)
            bfa_pkg::OP_ALLOC: begin
                w_chg  = w_pick;
                o_word = i_word | w_pick;
            end
            bfa_pkg::OP_FREE, bfa_pkg::OP_RANGE_FREE: begin
                w_chg  = i_word & w_mask;
                o_word = i_word & ~w_mask;
            end
            bfa_pkg::OP_RANGE_USED: begin
                w_chg  = w_free;
                o_word = i_word | w_mask;
            end
            default: begin
                w_chg  = '0;
                o_word = i_word;
            end
        endcase
    end

    always_comb begin
        o_idx = '0;
        for (int b = 0; b < WORD_W; b++) begin
            if (w_pick[b]) begin
                o_idx = o_idx | WBL'(b);
            end
        end
    end

    always_comb begin
        o_delta = '0;
        for (int b = 0; b < WORD_W; b++) begin
            o_delta = o_delta + (WBL+1)'(w_chg[b]);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/bfa_seq.sv */
// ============================================================================
// bfa_seq : request sequencer
// Walks bitmap words through the shared word unit, keeps the used count,
// runs the fill pass and holds the result register.
// ============================================================================
`default_nettype none

module bfa_seq #(
    parameter int MAX_FRAMES = 65536,
    parameter int PAGE_BYTES = 4096,
    parameter int WORD_W     = 64,
    parameter int WBL        = 6,
    parameter int MAP_WORDS  = 1024,
    parameter int AW         = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bfa_pkg::t_cfg                 i_cfg,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [bfa_pkg::OP_W-1:0]      i_op,
    input  wire logic [bfa_pkg::FIRST_W-1:0]   i_first_frame,
    input  wire logic [bfa_pkg::FRAME_W-1:0]   i_end_frame,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [bfa_pkg::STATUS_W-1:0]       o_status,
    output logic [bfa_pkg::PHYS_W-1:0]         o_phys_address,
    output logic [bfa_pkg::FRAME_W-1:0]        o_used_count,
    output logic [bfa_pkg::FRAME_W-1:0]        o_free_count,
    // bitmap store
    output logic                               o_ram_we,
    output logic [AW-1:0]                      o_ram_waddr,
    output logic [WORD_W-1:0]                  o_ram_wdata,
    output logic                               o_ram_re,
    output logic [AW-1:0]                      o_ram_raddr,
    input  wire logic [WORD_W-1:0]             i_ram_rdata,
    // word unit
    output logic [WORD_W-1:0]                  o_unit_word,
    output logic [WBL-1:0]                     o_unit_lo,
    output logic [WBL:0]                       o_unit_hi,
    output bfa_pkg::t_op                       o_unit_op,
    input  wire logic [WORD_W-1:0]             i_unit_word,
    input  wire logic                          i_unit_found,
    input  wire logic [WBL-1:0]                i_unit_idx,
    input  wire logic [WBL:0]                  i_unit_delta
);

    localparam int FW     = bfa_pkg::FRAME_W;
    localparam int PW     = bfa_pkg::PHYS_W;
    localparam int FXW    = ((AW + WBL > FW) ? AW + WBL : FW) + 1;
    localparam logic [FW-1:0] RESET_USED =
        (MAX_FRAMES < 65536) ? FW'(MAX_FRAMES) : bfa_pkg::TOTAL_RESET;

    function automatic logic [AW-1:0] word_of(input logic [FW-1:0] f);
        logic [FXW-1:0] x;
        x = FXW'(f) >> WBL;
        return x[AW-1:0];
    endfunction

    bfa_pkg::t_state  r_state, n_state;
    bfa_pkg::t_op     r_op, n_op;
    bfa_pkg::t_status r_status, n_status;
    logic [AW-1:0]    r_fill, n_fill;
    logic [AW-1:0]    r_word, n_word;
    logic [AW-1:0]    r_last, n_last;
    logic [FW-1:0]    r_start, n_start;
    logic [FW-1:0]    r_stop, n_stop;
    logic [FW-1:0]    r_used, n_used;
    logic [FW-1:0]    r_hit_f, n_hit_f;
    logic             r_hit_ok, n_hit_ok;
    logic             r_found, n_found;
    logic [WBL:0]     r_delta, n_delta;
    logic             r_out_valid, n_out_valid;
    bfa_pkg::t_status r_out_status, n_out_status;
    logic [PW-1:0]    r_out_phys, n_out_phys;
    logic [FW-1:0]    r_out_used, n_out_used;
    logic [FW-1:0]    r_out_free, n_out_free;

    bfa_pkg::t_op     w_in_op;
    logic [FW-1:0]    w_first;
    logic [FW-1:0]    w_rstart;
    logic [FW-1:0]    w_rstop;
    logic [FXW-1:0]   w_base;
    logic [FXW-1:0]   w_lo_diff;
    logic [FXW-1:0]   w_hi_diff;
    logic [FXW-1:0]   w_hit_full;
    logic [FW-1:0]    w_delta_ext;

    assign w_in_op  = bfa_pkg::t_op'(i_op);
    assign w_first  = FW'(i_first_frame);
    assign w_rstart = (w_in_op == bfa_pkg::OP_RANGE_FREE && w_first < i_cfg.reserved)
                      ? i_cfg.reserved : w_first;
    assign w_rstop  = (i_end_frame < i_cfg.total) ? i_end_frame : i_cfg.total;

    // frame window of the current word
    assign w_base     = FXW'(r_word) << WBL;
    assign w_lo_diff  = FXW'(r_start) - w_base;
    assign w_hi_diff  = FXW'(r_stop) - w_base;
    assign w_hit_full = w_base + FXW'(i_unit_idx);
    assign w_delta_ext = FW'(r_delta);

    assign o_unit_word = i_ram_rdata;
    assign o_unit_op   = r_op;
    assign o_unit_lo   = (FXW'(r_start) > w_base) ? w_lo_diff[WBL-1:0] : '0;
    assign o_unit_hi   = (FXW'(r_stop) >= w_base + FXW'(WORD_W))
                         ? (WBL+1)'(WORD_W) : w_hi_diff[WBL:0];

    assign o_ram_raddr = r_word;

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_status     = r_status;
        n_fill       = r_fill;
        n_word       = r_word;
        n_last       = r_last;
        n_start      = r_start;
        n_stop       = r_stop;
        n_used       = r_used;
        n_hit_f      = r_hit_f;
        n_hit_ok     = r_hit_ok;
        n_found      = r_found;
        n_delta      = r_delta;
        n_out_valid  = r_out_valid && i_out_stall;
        n_out_status = r_out_status;
        n_out_phys   = r_out_phys;
        n_out_used   = r_out_used;
        n_out_free   = r_out_free;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_word;
        o_ram_wdata  = i_unit_word;
        o_ram_re     = 1'b0;

        case (r_state)
            bfa_pkg::S_FILL: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = r_fill;
                o_ram_wdata = '1;
                if (r_fill == AW'(MAP_WORDS - 1)) begin
                    n_state = bfa_pkg::S_IDLE;
                end else begin
                    n_fill = r_fill + AW'(1);
                end
            end
            bfa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = w_in_op;
                    n_status = bfa_pkg::ST_OK;
                    n_hit_ok = 1'b0;
                    n_state  = bfa_pkg::S_DONE;
                    case (w_in_op)
                        bfa_pkg::OP_ALLOC: begin
                            if (i_cfg.total == '0) begin
                                n_status = bfa_pkg::ST_NOMEM;
                            end else begin
                                n_start = '0;
                                n_stop  = i_cfg.total;
                                n_word  = '0;
                                n_last  = word_of(i_cfg.total - FW'(1));
                                n_state = bfa_pkg::S_RD;
                            end
                        end
                        bfa_pkg::OP_FREE: begin
                            if (w_first >= i_cfg.total) begin
                                n_status = bfa_pkg::ST_RANGE;
                            end else begin
                                n_start = w_first;
                                n_stop  = w_first + FW'(1);
                                n_word  = word_of(w_first);
                                n_last  = word_of(w_first);
                                n_state = bfa_pkg::S_RD;
                            end
                        end
                        default: begin
                            // empty or inverted range answers ok at once
                            if (w_rstart < w_rstop) begin
                                n_start = w_rstart;
                                n_stop  = w_rstop;
                                n_word  = word_of(w_rstart);
                                n_last  = word_of(w_rstop - FW'(1));
                                n_state = bfa_pkg::S_RD;
                            end
                        end
                    endcase
                end
            end
            bfa_pkg::S_RD: begin
                o_ram_re = 1'b1;
                n_state  = bfa_pkg::S_EVAL;
            end
            bfa_pkg::S_EVAL: begin
                o_ram_we = 1'b1;
                n_delta  = i_unit_delta;
                n_found  = i_unit_found;
                n_hit_f  = w_hit_full[FW-1:0];
                n_state  = bfa_pkg::S_CNT;
            end
            bfa_pkg::S_CNT: begin
                if (r_op == bfa_pkg::OP_ALLOC || r_op == bfa_pkg::OP_RANGE_USED) begin
                    n_used = r_used + w_delta_ext;
                end else begin
                    n_used = r_used - w_delta_ext;
                end
                case (r_op)
                    bfa_pkg::OP_ALLOC: begin
                        if (r_found) begin
                            n_hit_ok = 1'b1;
                            n_state  = bfa_pkg::S_DONE;
                        end else if (r_word == r_last) begin
                            n_status = bfa_pkg::ST_NOMEM;
                            n_state  = bfa_pkg::S_DONE;
                        end else begin
                            n_word  = r_word + AW'(1);
                            n_state = bfa_pkg::S_RD;
                        end
                    end
                    bfa_pkg::OP_FREE: begin
                        n_status = (r_delta == '0) ? bfa_pkg::ST_DBL_FREE : bfa_pkg::ST_OK;
                        n_state  = bfa_pkg::S_DONE;
                    end
                    default: begin
                        if (r_word == r_last) begin
                            n_state = bfa_pkg::S_DONE;
                        end else begin
                            n_word  = r_word + AW'(1);
                            n_state = bfa_pkg::S_RD;
                        end
                    end
                endcase
            end
            bfa_pkg::S_DONE: begin
                // hold until the result register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_phys   = r_hit_ok ? (PW'(r_hit_f) * PW'(PAGE_BYTES)) : '0;
                    n_out_used   = r_used;
                    n_out_free   = i_cfg.total - r_used;
                    n_state      = bfa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bfa_pkg::S_IDLE;
            end
        endcase

        // a total_frames write marks every frame used
        if (i_cfg.reload) begin
            n_state = bfa_pkg::S_FILL;
            n_fill  = '0;
            n_used  = i_cfg.reload_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bfa_pkg::S_FILL;
            r_fill      <= '0;
            r_used      <= RESET_USED;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_status     <= n_status;
        r_word       <= n_word;
        r_last       <= n_last;
        r_start      <= n_start;
        r_stop       <= n_stop;
        r_hit_f      <= n_hit_f;
        r_hit_ok     <= n_hit_ok;
        r_found      <= n_found;
        r_delta      <= n_delta;
        r_out_status <= n_out_status;
        r_out_phys   <= n_out_phys;
        r_out_used   <= n_out_used;
        r_out_free   <= n_out_free;
    end

    assign o_in_stall     = (r_state != bfa_pkg::S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_phys_address = r_out_phys;
    assign o_used_count   = r_out_used;
    assign o_free_count   = r_out_free;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request beat taken but sequencer still open");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bfa_pkg::S_IDLE) |-> (r_used <= i_cfg.total))
        else $error("used count above managed frame count");

    a_phys_only_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != bfa_pkg::ST_OK) |-> (r_out_phys == '0))
        else $error("address reported on a failed request");

endmodule

`default_nettype wire

/* rtl/core/bitmap_frame_allocator_unit.sv */
// ============================================================================
// bitmap_frame_allocator_unit : first-fit bitmap page frame allocator
//
// Request channel (i_in_valid / o_in_stall): op, first_frame, end_frame.
// One request is taken at a time; o_in_stall stays high until its result
// has been placed in the result register.
// Result channel (o_out_valid / i_out_stall): status, phys_address,
// used_count, free_count, one beat per request. The result register holds
// while the receiver stalls, and a new request is taken meanwhile.
// Every bitmap word a request touches passes through the shared word unit
// in the steps read, update and write, and count. A free touches one word;
// an alloc or range visits words in turn, up to every word for a full scan.
// Reset, and every write of total_frames, starts a fill pass that writes
// one bitmap word per cycle (1024 words at the defaults) and marks all
// frames used; requests stall for its length. Register writes go on
// the plain write port and are registered. Word width rounds up to a
// power of two.
// ============================================================================
`default_nettype none

module bitmap_frame_allocator_unit #(
    parameter int MAX_FRAMES    = 65536,
    parameter int PAGE_BYTES    = 4096,
    parameter int MAP_WORD_BITS = 64
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration
    input  wire logic                            i_cfg_we,
    input  wire logic [bfa_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [bfa_pkg::FRAME_W-1:0]     i_cfg_data,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [bfa_pkg::OP_W-1:0]        i_op,
    input  wire logic [bfa_pkg::FIRST_W-1:0]     i_first_frame,
    input  wire logic [bfa_pkg::FRAME_W-1:0]     i_end_frame,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [bfa_pkg::STATUS_W-1:0]         o_status,
    output logic [bfa_pkg::PHYS_W-1:0]           o_phys_address,
    output logic [bfa_pkg::FRAME_W-1:0]          o_used_count,
    output logic [bfa_pkg::FRAME_W-1:0]          o_free_count
);

    localparam int FW        = bfa_pkg::FRAME_W;
    localparam int WBL       = $clog2(MAP_WORD_BITS);
    localparam int WORD_W    = 1 << WBL;
    localparam int MAP_WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam logic [FW-1:0] TOTAL_CAP =
        (MAX_FRAMES >= (1 << FW) - 1) ? {FW{1'b1}} : FW'(MAX_FRAMES);

    logic [FW-1:0]  r_total;
    logic [FW-1:0]  r_reserved;
    bfa_pkg::t_cfg  w_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= bfa_pkg::TOTAL_RESET;
            r_reserved <= bfa_pkg::RESERVED_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bfa_pkg::CFG_TOTAL_FRAMES: r_total    <= i_cfg_data;
                bfa_pkg::CFG_RESERVED_LOW: r_reserved <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // clamp the frame count to what the bitmap holds
    assign w_cfg.total        = (r_total > TOTAL_CAP) ? TOTAL_CAP : r_total;
    assign w_cfg.reserved     = r_reserved;
    assign w_cfg.reload       = i_cfg_we && (i_cfg_index == bfa_pkg::CFG_TOTAL_FRAMES);
    assign w_cfg.reload_total = (i_cfg_data > TOTAL_CAP) ? TOTAL_CAP : i_cfg_data;

    logic              w_ram_we;
    logic [AW-1:0]     w_ram_waddr;
    logic [WORD_W-1:0] w_ram_wdata;
    logic              w_ram_re;
    logic [AW-1:0]     w_ram_raddr;
    logic [WORD_W-1:0] w_ram_rdata;
    logic [WORD_W-1:0] w_unit_in;
    logic [WBL-1:0]    w_unit_lo;
    logic [WBL:0]      w_unit_hi;
    bfa_pkg::t_op      w_unit_op;
    logic [WORD_W-1:0] w_unit_out;
    logic              w_unit_found;
    logic [WBL-1:0]    w_unit_idx;
    logic [WBL:0]      w_unit_delta;

    bfa_map_ram #(
        .DEPTH (MAP_WORDS),
        .WIDTH (WORD_W),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    bfa_word_unit #(
        .WORD_W (WORD_W),
        .WBL    (WBL)
    ) u_unit (
        .i_word  (w_unit_in),
        .i_lo    (w_unit_lo),
        .i_hi    (w_unit_hi),
        .i_op    (w_unit_op),
        .o_word  (w_unit_out),
        .o_found (w_unit_found),
        .o_idx   (w_unit_idx),
        .o_delta (w_unit_delta)
    );

    bfa_seq #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BYTES (PAGE_BYTES),
        .WORD_W     (WORD_W),
        .WBL        (WBL),
        .MAP_WORDS  (MAP_WORDS),
        .AW         (AW)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (w_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (i_op),
        .i_first_frame  (i_first_frame),
        .i_end_frame    (i_end_frame),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_phys_address (o_phys_address),
        .o_used_count   (o_used_count),
        .o_free_count   (o_free_count),
        .o_ram_we       (w_ram_we),
        .o_ram_waddr    (w_ram_waddr),
        .o_ram_wdata    (w_ram_wdata),
        .o_ram_re       (w_ram_re),
        .o_ram_raddr    (w_ram_raddr),
        .i_ram_rdata    (w_ram_rdata),
        .o_unit_word    (w_unit_in),
        .o_unit_lo      (w_unit_lo),
        .o_unit_hi      (w_unit_hi),
        .o_unit_op      (w_unit_op),
        .i_unit_word    (w_unit_out),
        .i_unit_found   (w_unit_found),
        .i_unit_idx     (w_unit_idx),
        .i_unit_delta   (w_unit_delta)
    );

endmodule

`default_nettype wire
